// ----- rtl/seg_pkg.sv -----
package seg_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int TOL_W     = 16;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = DIFF_W + COORD_W;
  localparam int C_W       = PROD_W + 1;
  localparam int DET_W     = 2 * DIFF_W + 1;
  localparam int CLO_W     = DIFF_W;
  localparam int CHI_W     = C_W - CLO_W;
  localparam int PPL_W     = DIFF_W + CLO_W + 1;
  localparam int PPH_W     = DIFF_W + CHI_W;
  localparam int NUM_W     = 100;
  localparam int QB        = 33;
  localparam int QW        = QB + 1;
  localparam int PRE_STG   = 8;
  localparam int LAST_STG  = PRE_STG + QB;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'((1 << FRAC_BITS) / 100);

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_OUTSIDE  = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x1lo;
    logic signed [COORD_W-1:0] x1hi;
    logic signed [COORD_W-1:0] y1lo;
    logic signed [COORD_W-1:0] y1hi;
    logic signed [COORD_W-1:0] x2lo;
    logic signed [COORD_W-1:0] x2hi;
    logic signed [COORD_W-1:0] y2lo;
    logic signed [COORD_W-1:0] y2hi;
  } box_t;

  function automatic logic in_span(logic signed [QW-1:0] v, logic signed [COORD_W-1:0] lo,
                                   logic signed [COORD_W-1:0] hi, logic [TOL_W-1:0] tol);
    logic signed [QW-1:0] eps;
    logic signed [QW-1:0] lo_w;
    logic signed [QW-1:0] hi_w;
    eps  = $signed(QW'(tol));
    lo_w = QW'(lo) - eps;
    hi_w = QW'(hi) + eps;
    return (lo_w < v) && (v < hi_w);
  endfunction

  function automatic logic [COORD_W-1:0] sat32(logic signed [QW-1:0] v);
    logic signed [QW-1:0] vmax;
    logic signed [QW-1:0] vmin;
    vmax = QW'($signed({1'b0, {(COORD_W-1){1'b1}}}));
    vmin = QW'($signed({1'b1, {(COORD_W-1){1'b0}}}));
    if (v > vmax) begin
      return vmax[COORD_W-1:0];
    end else if (v < vmin) begin
      return vmin[COORD_W-1:0];
    end
    return v[COORD_W-1:0];
  endfunction

endpackage

// ----- rtl/seg_if.sv -----
interface seg_in_if;
  import seg_pkg::*;
  logic valid;
  logic ready;
  logic signed [COORD_W-1:0] first_start_x;
  logic signed [COORD_W-1:0] first_start_y;
  logic signed [COORD_W-1:0] first_end_x;
  logic signed [COORD_W-1:0] first_end_y;
  logic signed [COORD_W-1:0] second_start_x;
  logic signed [COORD_W-1:0] second_start_y;
  logic signed [COORD_W-1:0] second_end_x;
  logic signed [COORD_W-1:0] second_end_y;
  modport source (output valid, first_start_x, first_start_y, first_end_x, first_end_y,
                  second_start_x, second_start_y, second_end_x, second_end_y, input ready);
  modport sink (input valid, first_start_x, first_start_y, first_end_x, first_end_y,
                second_start_x, second_start_y, second_end_x, second_end_y, output ready);
endinterface

interface seg_out_if;
  import seg_pkg::*;
  logic valid;
  logic ready;
  logic signed [COORD_W-1:0] cross_x;
  logic signed [COORD_W-1:0] cross_y;
  logic [1:0] status;
  modport source (output valid, cross_x, cross_y, status, input ready);
  modport sink (input valid, cross_x, cross_y, status, output ready);
endinterface

interface seg_cfg_if;
  import seg_pkg::*;
  logic valid;
  logic ready;
  logic [TOL_W-1:0] tolerance;
  modport source (output valid, tolerance, input ready);
  modport sink (input valid, tolerance, output ready);
endinterface

// ----- rtl/segment_intersection_2d.sv -----
// Throughput: one request per cycle; the whole pipeline holds while the output is stalled.
// Stages: differences, products, line constants, partial products, numerators,
// magnitudes, range check, then one quotient bit per stage for 33 stages.
// Reset clears all valid bits, the output valid included; tolerance returns to 655.
module segment_intersection_2d (
  input  logic       clk_i,
  input  logic       rst_ni,
  seg_in_if.sink     seg_i,
  seg_cfg_if.sink    cfg_i,
  seg_out_if.source  res_o
);
  import seg_pkg::*;

  logic en;
  logic [TOL_W-1:0] tol_q;
  logic [LAST_STG:1] v_q;
  box_t box_q [1:LAST_STG];

  logic signed [DIFF_W-1:0] a1_1_q, b1_1_q, a2_1_q, b2_1_q;
  logic signed [COORD_W-1:0] px_q, py_q, rx_q, ry_q;

  logic signed [DIFF_W-1:0] a1_2_q, b1_2_q, a2_2_q, b2_2_q;
  logic signed [PROD_W-1:0] m1_q, m2_q, m3_q, m4_q;
  logic signed [2*DIFF_W-1:0] md1_q, md2_q;

  logic signed [DIFF_W-1:0] a1_3_q, b1_3_q, a2_3_q, b2_3_q;
  logic signed [C_W-1:0] c1_q, c2_q;
  logic signed [DET_W-1:0] det3_q, det4_q, det5_q, det6_q;

  logic signed [PPL_W-1:0] l_b2c1_q, l_b1c2_q, l_a1c2_q, l_a2c1_q;
  logic signed [PPH_W-1:0] h_b2c1_q, h_b1c2_q, h_a1c2_q, h_a2c1_q;

  logic signed [NUM_W-1:0] p_b2c1_q, p_b1c2_q, p_a1c2_q, p_a2c1_q;
  logic signed [NUM_W-1:0] nx_q, ny_q;

  logic [NUM_W-1:0] nxm_q, nym_q;
  logic [DET_W-1:0] dm7_q;
  logic sgx7_q, sgy7_q, zero7_q;

  logic [NUM_W-1:0] remx_q [0:QB];
  logic [NUM_W-1:0] remy_q [0:QB];
  logic [QB-1:0]    qx_q   [0:QB];
  logic [QB-1:0]    qy_q   [0:QB];
  logic [DET_W-1:0] dm_q   [0:QB];
  logic             sgx_q  [0:QB];
  logic             sgy_q  [0:QB];
  logic             ovx_q  [0:QB];
  logic             ovy_q  [0:QB];
  logic             zero_q [0:QB];

  logic [NUM_W-1:0] dsh    [0:QB-1];
  logic             takex  [0:QB-1];
  logic             takey  [0:QB-1];
  logic [NUM_W-1:0] remx_d [0:QB-1];
  logic [NUM_W-1:0] remy_d [0:QB-1];

  logic signed [QW-1:0] xs, ys;
  logic in_box;
  box_t bl;

  logic out_valid_q;
  logic signed [COORD_W-1:0] cross_x_q, cross_y_q;
  status_e status_q;

  assign en          = !out_valid_q || res_o.ready;
  assign seg_i.ready = en;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      tol_q <= cfg_i.tolerance;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v_q         <= {v_q[LAST_STG-1:1], seg_i.valid};
      out_valid_q <= v_q[LAST_STG];
    end
  end

  always_comb begin
    for (int j = 0; j < QB; j++) begin
      dsh[j]    = NUM_W'(dm_q[j]) << (QB - 1 - j);
      takex[j]  = remx_q[j] >= dsh[j];
      takey[j]  = remy_q[j] >= dsh[j];
      remx_d[j] = takex[j] ? remx_q[j] - dsh[j] : remx_q[j];
      remy_d[j] = takey[j] ? remy_q[j] - dsh[j] : remy_q[j];
    end
  end

  always_comb begin
    bl     = box_q[LAST_STG];
    xs     = sgx_q[QB] ? -$signed({1'b0, qx_q[QB]}) : $signed({1'b0, qx_q[QB]});
    ys     = sgy_q[QB] ? -$signed({1'b0, qy_q[QB]}) : $signed({1'b0, qy_q[QB]});
    in_box = !ovx_q[QB] && !ovy_q[QB] &&
             in_span(xs, bl.x1lo, bl.x1hi, tol_q) && in_span(ys, bl.y1lo, bl.y1hi, tol_q) &&
             in_span(xs, bl.x2lo, bl.x2hi, tol_q) && in_span(ys, bl.y2lo, bl.y2hi, tol_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // stage 1: direction terms and bounding boxes
      a1_1_q <= DIFF_W'(seg_i.first_end_y) - DIFF_W'(seg_i.first_start_y);
      b1_1_q <= DIFF_W'(seg_i.first_start_x) - DIFF_W'(seg_i.first_end_x);
      a2_1_q <= DIFF_W'(seg_i.second_end_y) - DIFF_W'(seg_i.second_start_y);
      b2_1_q <= DIFF_W'(seg_i.second_start_x) - DIFF_W'(seg_i.second_end_x);
      px_q   <= seg_i.first_start_x;
      py_q   <= seg_i.first_start_y;
      rx_q   <= seg_i.second_start_x;
      ry_q   <= seg_i.second_start_y;
      box_q[1].x1lo <= (seg_i.first_start_x < seg_i.first_end_x) ?
                       seg_i.first_start_x : seg_i.first_end_x;
      box_q[1].x1hi <= (seg_i.first_start_x < seg_i.first_end_x) ?
                       seg_i.first_end_x : seg_i.first_start_x;
      box_q[1].y1lo <= (seg_i.first_start_y < seg_i.first_end_y) ?
                       seg_i.first_start_y : seg_i.first_end_y;
      box_q[1].y1hi <= (seg_i.first_start_y < seg_i.first_end_y) ?
                       seg_i.first_end_y : seg_i.first_start_y;
      box_q[1].x2lo <= (seg_i.second_start_x < seg_i.second_end_x) ?
                       seg_i.second_start_x : seg_i.second_end_x;
      box_q[1].x2hi <= (seg_i.second_start_x < seg_i.second_end_x) ?
                       seg_i.second_end_x : seg_i.second_start_x;
      box_q[1].y2lo <= (seg_i.second_start_y < seg_i.second_end_y) ?
                       seg_i.second_start_y : seg_i.second_end_y;
      box_q[1].y2hi <= (seg_i.second_start_y < seg_i.second_end_y) ?
                       seg_i.second_end_y : seg_i.second_start_y;
      for (int k = 2; k <= LAST_STG; k++) begin
        box_q[k] <= box_q[k-1];
      end

      // stage 2
      m1_q   <= a1_1_q * px_q;
      m2_q   <= b1_1_q * py_q;
      m3_q   <= a2_1_q * rx_q;
      m4_q   <= b2_1_q * ry_q;
      md1_q  <= a1_1_q * b2_1_q;
      md2_q  <= a2_1_q * b1_1_q;
      a1_2_q <= a1_1_q;
      b1_2_q <= b1_1_q;
      a2_2_q <= a2_1_q;
      b2_2_q <= b2_1_q;

      // stage 3
      c1_q   <= C_W'(m1_q) + C_W'(m2_q);
      c2_q   <= C_W'(m3_q) + C_W'(m4_q);
      det3_q <= DET_W'(md1_q) - DET_W'(md2_q);
      a1_3_q <= a1_2_q;
      b1_3_q <= b1_2_q;
      a2_3_q <= a2_2_q;
      b2_3_q <= b2_2_q;

      // stage 4: split line constants into partial products
      l_b2c1_q <= b2_3_q * $signed({1'b0, c1_q[CLO_W-1:0]});
      l_b1c2_q <= b1_3_q * $signed({1'b0, c2_q[CLO_W-1:0]});
      l_a1c2_q <= a1_3_q * $signed({1'b0, c2_q[CLO_W-1:0]});
      l_a2c1_q <= a2_3_q * $signed({1'b0, c1_q[CLO_W-1:0]});
      h_b2c1_q <= b2_3_q * $signed(c1_q[C_W-1:CLO_W]);
      h_b1c2_q <= b1_3_q * $signed(c2_q[C_W-1:CLO_W]);
      h_a1c2_q <= a1_3_q * $signed(c2_q[C_W-1:CLO_W]);
      h_a2c1_q <= a2_3_q * $signed(c1_q[C_W-1:CLO_W]);
      det4_q   <= det3_q;

      // stage 5
      p_b2c1_q <= (NUM_W'(h_b2c1_q) <<< CLO_W) + NUM_W'(l_b2c1_q);
      p_b1c2_q <= (NUM_W'(h_b1c2_q) <<< CLO_W) + NUM_W'(l_b1c2_q);
      p_a1c2_q <= (NUM_W'(h_a1c2_q) <<< CLO_W) + NUM_W'(l_a1c2_q);
      p_a2c1_q <= (NUM_W'(h_a2c1_q) <<< CLO_W) + NUM_W'(l_a2c1_q);
      det5_q   <= det4_q;

      // stage 6
      nx_q   <= p_b2c1_q - p_b1c2_q;
      ny_q   <= p_a1c2_q - p_a2c1_q;
      det6_q <= det5_q;

      // stage 7: magnitudes and quotient signs
      nxm_q   <= nx_q[NUM_W-1] ? NUM_W'(-nx_q) : NUM_W'(nx_q);
      nym_q   <= ny_q[NUM_W-1] ? NUM_W'(-ny_q) : NUM_W'(ny_q);
      dm7_q   <= det6_q[DET_W-1] ? DET_W'(-det6_q) : DET_W'(det6_q);
      sgx7_q  <= nx_q[NUM_W-1] ^ det6_q[DET_W-1];
      sgy7_q  <= ny_q[NUM_W-1] ^ det6_q[DET_W-1];
      zero7_q <= (det6_q == '0);

      // stage 8: flag quotients too large for any box
      remx_q[0] <= nxm_q;
      remy_q[0] <= nym_q;
      qx_q[0]   <= '0;
      qy_q[0]   <= '0;
      dm_q[0]   <= dm7_q;
      sgx_q[0]  <= sgx7_q;
      sgy_q[0]  <= sgy7_q;
      ovx_q[0]  <= nxm_q >= {dm7_q, {QB{1'b0}}};
      ovy_q[0]  <= nym_q >= {dm7_q, {QB{1'b0}}};
      zero_q[0] <= zero7_q;

      // one quotient bit per stage
      for (int j = 0; j < QB; j++) begin
        remx_q[j+1] <= remx_d[j];
        remy_q[j+1] <= remy_d[j];
        qx_q[j+1]   <= qx_q[j] | (QB'(takex[j]) << (QB - 1 - j));
        qy_q[j+1]   <= qy_q[j] | (QB'(takey[j]) << (QB - 1 - j));
        dm_q[j+1]   <= dm_q[j];
        sgx_q[j+1]  <= sgx_q[j];
        sgy_q[j+1]  <= sgy_q[j];
        ovx_q[j+1]  <= ovx_q[j];
        ovy_q[j+1]  <= ovy_q[j];
        zero_q[j+1] <= zero_q[j];
      end

      // output register
      if (zero_q[QB]) begin
        status_q  <= ST_PARALLEL;
        cross_x_q <= '0;
        cross_y_q <= '0;
      end else if (in_box) begin
        status_q  <= ST_FOUND;
        cross_x_q <= sat32(xs);
        cross_y_q <= sat32(ys);
      end else begin
        status_q  <= ST_OUTSIDE;
        cross_x_q <= '0;
        cross_y_q <= '0;
      end
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.cross_x = cross_x_q;
  assign res_o.cross_y = cross_y_q;
  assign res_o.status  = status_q;

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q != ST_FOUND) |-> (cross_x_q == '0) && (cross_y_q == '0))
    else $error("failed crossing carries a nonzero point");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (status_q == ST_FOUND) || (status_q == ST_PARALLEL) ||
                    (status_q == ST_OUTSIDE))
    else $error("status code out of range");

  a_tail_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> out_valid_q == $past(v_q[LAST_STG]))
    else $error("last stage lost or repeated a request");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q))
    else $error("pipeline moved during a stall");

endmodule
